[src/i2csrp_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// i2csrp_pkg - shared types and codes for the i2c slave register port
// event and result word layouts, action, phase, kind and register codes
// ----------------------------------------------------------------------------
package i2csrp_pkg;

    // bus event kinds
    localparam logic [1:0] KIND_START = 2'd0;
    localparam logic [1:0] KIND_STOP  = 2'd1;
    localparam logic [1:0] KIND_SHIFT = 2'd2;

    // bus actions
    localparam logic [2:0] ACT_NONE  = 3'd0;
    localparam logic [2:0] ACT_IDLE  = 3'd1;
    localparam logic [2:0] ACT_RECV  = 3'd2;
    localparam logic [2:0] ACT_ACK   = 3'd3;
    localparam logic [2:0] ACT_NACK  = 3'd4;
    localparam logic [2:0] ACT_SEND  = 3'd5;
    localparam logic [2:0] ACT_RDACK = 3'd6;

    // protocol phases
    localparam logic [3:0] PH_IDLE     = 4'd0;
    localparam logic [3:0] PH_START    = 4'd1;
    localparam logic [3:0] PH_RSTART   = 4'd2;
    localparam logic [3:0] PH_W_ADDR   = 4'd3;
    localparam logic [3:0] PH_W_ACKED  = 4'd4;
    localparam logic [3:0] PH_W_TOACK  = 4'd5;
    localparam logic [3:0] PH_W_NACKED = 4'd6;
    localparam logic [3:0] PH_R_ADDR   = 4'd7;
    localparam logic [3:0] PH_R_SENT   = 4'd8;
    localparam logic [3:0] PH_R_CHECK  = 4'd9;

    // configuration registers
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_OWN_ADDRESS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LAST_INDEX  = 1'd1;

    // read/write direction bit of the address byte
    localparam logic [7:0] RW_READ_MASK = 8'h01;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] line_byte;
    } evt_word_t;

    typedef struct packed {
        logic [2:0] action;
        logic [7:0] tx_byte;
        logic [3:0] phase;
    } rsp_word_t;

    // access from the protocol engine to the register store
    typedef struct packed {
        logic       rd_en;
        logic       wr_en;
        logic [7:0] addr;
        logic [7:0] wdata;
    } store_req_t;

endpackage
`default_nettype wire

[src/i2csrp_top.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// i2c_slave_register_port_core - byte-level i2c slave with register pointer
// top level: config registers, result register and handshakes
// ----------------------------------------------------------------------------
// One event word (start, stop, shift complete) is accepted per clock cycle and
// its result word appears in the result register on the next cycle, so the
// sustained rate is one word per cycle unless the result side stalls. The event
// side is ready whenever the result register is empty or being taken in the
// same cycle. The protocol engine updates phase, pointer and stop tracking in
// a single step; the register store is a ram whose registered read port
// delivers the byte to send together with the result. Every store entry has a
// written flag cleared at reset, so the store reads as zero straight after
// reset with no clearing pass. Configuration writes are taken at any edge
// with cfg_we high but should only be issued while the block is idle.
// ----------------------------------------------------------------------------
module i2c_slave_register_port_core #(
    parameter int BUF_DEPTH = 256
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                evt_valid,
    output logic                                     evt_ready,
    input  wire i2csrp_pkg::evt_word_t               evt_word,
    output logic                                     rsp_valid,
    input  wire logic                                rsp_ready,
    output i2csrp_pkg::rsp_word_t                    rsp_word,
    input  wire logic                                cfg_we,
    input  wire logic [i2csrp_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [7:0]                          cfg_data
);
    import i2csrp_pkg::*;

    logic [6:0]  own_address_reg;
    logic [7:0]  last_index_reg;
    logic        rsp_valid_reg;
    logic [2:0]  rsp_action_reg;
    logic [3:0]  rsp_phase_reg;
    logic        step;
    logic [2:0]  action;
    logic [3:0]  phase;
    store_req_t  req;
    logic [7:0]  rd_byte;

    // a word goes in when the result slot is free or draining
    assign evt_ready = !rsp_valid_reg || rsp_ready;
    assign step      = evt_valid && evt_ready;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_address_reg <= 7'd0;
            last_index_reg  <= 8'd255;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_OWN_ADDRESS: own_address_reg <= cfg_data[6:0];
                CFG_LAST_INDEX:  last_index_reg  <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    i2csrp_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (step),
        .evt        (evt_word),
        .own_address(own_address_reg),
        .last_index (last_index_reg),
        .action     (action),
        .phase      (phase),
        .req        (req)
    );

    i2csrp_store #(
        .BUF_DEPTH(BUF_DEPTH)
    ) u_store (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (req),
        .rd_byte(rd_byte)
    );

    // result valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (evt_ready)
        begin
            rsp_valid_reg <= evt_valid;
        end
    end

    // result payload, loaded with the accepted word
    always_ff @(posedge clk)
    begin
        if (step)
        begin
            rsp_action_reg <= action;
            rsp_phase_reg  <= phase;
        end
    end

    // the store read data only counts for a send data result
    assign rsp_valid        = rsp_valid_reg;
    assign rsp_word.action  = rsp_action_reg;
    assign rsp_word.phase   = rsp_phase_reg;
    assign rsp_word.tx_byte = (rsp_action_reg == ACT_SEND) ? rd_byte : 8'h00;

    // an accepted word always leaves a result behind
    a_step_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        step |=> rsp_valid)
        else $error("accepted word produced no result");

    // a start always asks for the address byte
    a_start_receives: assert property (@(posedge clk) disable iff (!rst_n)
        step && evt_word.kind == KIND_START |=> rsp_word.action == ACT_RECV &&
        (rsp_word.phase == PH_START || rsp_word.phase == PH_RSTART))
        else $error("start event did not move to a start phase");

    // a stop leaves the phase where it was
    a_stop_keeps_phase: assert property (@(posedge clk) disable iff (!rst_n)
        step && evt_word.kind == KIND_STOP && rsp_valid
        |=> rsp_word.phase == $past(rsp_word.phase) && rsp_word.action == ACT_NONE)
        else $error("stop event changed the phase");

    // phases stay within the dense numbering
    a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp_word.phase <= PH_R_CHECK)
        else $error("result phase out of range");

endmodule
`default_nettype wire

[src/i2csrp_ram.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// i2csrp_ram - generic single write port ram
// one write port, one read port with registered read data
// ----------------------------------------------------------------------------
module i2csrp_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 256,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

[src/i2csrp_store.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// i2csrp_store - register store with per-entry valid bits
// ram plus written flags so that unwritten entries read as zero after reset
// ----------------------------------------------------------------------------
module i2csrp_store #(
    parameter int BUF_DEPTH = 256
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire i2csrp_pkg::store_req_t req,
    output logic [7:0]                  rd_byte
);
    import i2csrp_pkg::*;

    localparam int AW = $clog2(BUF_DEPTH);

    logic [BUF_DEPTH-1:0] valid_reg;
    logic [BUF_DEPTH-1:0] valid_next;
    logic                 hit_reg;
    logic                 hit_next;
    logic                 in_range;
    logic [AW-1:0]        idx;
    logic [7:0]           ram_q;

    assign in_range = (32'(req.addr) < BUF_DEPTH);
    assign idx      = req.addr[AW-1:0];

    always_comb
    begin
        valid_next = valid_reg;
        if (req.wr_en && in_range)
        begin
            valid_next[idx] = 1'b1;
        end
        hit_next = hit_reg;
        // out of range reads give zero
        if (req.rd_en)
        begin
            hit_next = in_range && valid_reg[idx];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            hit_reg   <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            hit_reg   <= hit_next;
        end
    end

    i2csrp_ram #(
        .WIDTH (8),
        .DEPTH (BUF_DEPTH),
        .ADDR_W(AW)
    ) u_ram (
        .clk  (clk),
        .we   (req.wr_en && in_range),
        .waddr(idx),
        .wdata(req.wdata),
        .re   (req.rd_en),
        .raddr(idx),
        .rdata(ram_q)
    );

    assign rd_byte = hit_reg ? ram_q : 8'h00;

endmodule
`default_nettype wire

[src/i2csrp_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// i2csrp_ctrl - i2c slave protocol engine
// phase, pointer and stop tracking; one event per step
// ----------------------------------------------------------------------------
module i2csrp_ctrl (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   step,
    input  wire i2csrp_pkg::evt_word_t  evt,
    input  wire logic [6:0]             own_address,
    input  wire logic [7:0]             last_index,
    output logic [2:0]                  action,
    output logic [3:0]                  phase,
    output i2csrp_pkg::store_req_t      req
);
    import i2csrp_pkg::*;

    logic [3:0] phase_reg;
    logic [3:0] phase_next;
    logic [7:0] pointer_reg;
    logic [7:0] pointer_next;
    logic       pending_reg;
    logic       pending_next;
    logic       stop_seen_reg;
    logic       stop_seen_next;
    logic [7:0] b;

    assign b = evt.line_byte;

    always_comb
    begin
        phase_next     = phase_reg;
        pointer_next   = pointer_reg;
        pending_next   = pending_reg;
        stop_seen_next = stop_seen_reg;
        action         = ACT_NONE;
        req.rd_en      = 1'b0;
        req.wr_en      = 1'b0;
        req.addr       = pointer_reg;
        req.wdata      = b;
        case (evt.kind)
            KIND_START:
            begin
                phase_next     = stop_seen_reg ? PH_START : PH_RSTART;
                stop_seen_next = 1'b0;
                action         = ACT_RECV;
            end
            KIND_STOP:
            begin
                stop_seen_next = 1'b1;
            end
            KIND_SHIFT:
            begin
                case (phase_reg)
                    PH_START, PH_RSTART:
                    begin
                        // fresh start resets the pointer, repeated start keeps it
                        if (phase_reg == PH_START)
                        begin
                            pointer_next = 8'h00;
                        end
                        if (b[7:1] == own_address)
                        begin
                            phase_next = ((b & RW_READ_MASK) != 8'h00) ? PH_R_ADDR
                                                                      : PH_W_ADDR;
                            action     = ACT_ACK;
                        end
                        else
                        begin
                            phase_next     = PH_IDLE;
                            stop_seen_next = 1'b0;
                            action         = ACT_IDLE;
                        end
                    end
                    PH_W_ADDR, PH_W_ACKED:
                    begin
                        if (phase_reg == PH_W_ADDR)
                        begin
                            pending_next = 1'b1;
                        end
                        phase_next = PH_W_TOACK;
                        action     = ACT_RECV;
                    end
                    PH_W_TOACK:
                    begin
                        if (pending_reg)
                        begin
                            pointer_next = b;
                            pending_next = 1'b0;
                            phase_next   = PH_W_ACKED;
                            action       = ACT_ACK;
                        end
                        else
                        begin
                            req.wr_en    = step;
                            pointer_next = pointer_reg + 8'd1;
                            if (pointer_reg < last_index)
                            begin
                                phase_next = PH_W_ACKED;
                                action     = ACT_ACK;
                            end
                            else
                            begin
                                phase_next = PH_W_NACKED;
                                action     = ACT_NACK;
                            end
                        end
                    end
                    PH_W_NACKED:
                    begin
                        phase_next     = PH_IDLE;
                        stop_seen_next = 1'b0;
                        action         = ACT_IDLE;
                    end
                    PH_R_ADDR, PH_R_CHECK:
                    begin
                        // master nack or pointer past the end closes the read
                        if (phase_reg == PH_R_CHECK &&
                            (b != 8'h00 || pointer_reg > last_index))
                        begin
                            phase_next     = PH_IDLE;
                            stop_seen_next = 1'b0;
                            action         = ACT_IDLE;
                        end
                        else
                        begin
                            req.rd_en    = step;
                            pointer_next = pointer_reg + 8'd1;
                            phase_next   = PH_R_SENT;
                            action       = ACT_SEND;
                        end
                    end
                    PH_R_SENT:
                    begin
                        phase_next = PH_R_CHECK;
                        action     = ACT_RDACK;
                    end
                    default:
                    begin
                        phase_next = PH_IDLE;
                    end
                endcase
            end
            default:
            begin
            end
        endcase
    end

    assign phase = phase_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            pointer_reg   <= 8'h00;
            pending_reg   <= 1'b0;
            stop_seen_reg <= 1'b1;
        end
        else if (step)
        begin
            phase_reg     <= phase_next;
            pointer_reg   <= pointer_next;
            pending_reg   <= pending_next;
            stop_seen_reg <= stop_seen_next;
        end
    end

endmodule
`default_nettype wire

[test/testbench.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// testbench - self-checking bench for i2c_slave_register_port_core
// Drives bus event words through the valid/ready event channel and collects
// result words under random idling and stalling on both sides. A scoreboard
// class keeps its own copy of the protocol phase, register pointer, stop
// tracking and register store. From that copy it works out the result word
// for every accepted event and compares each received word field by field.
// Several register settings are run, the extremes among them.
// ----------------------------------------------------------------------------
module testbench;

    import i2csrp_pkg::*;

    localparam int CYCLE_LIMIT     = 400000;
    localparam int PHASE_COUNT     = 8;
    localparam int WORDS_PER_PHASE = 200;

    // ------------------------------------------------------------------------
    // scoreboard: predicted slave state and the result words still due
    // ------------------------------------------------------------------------
    class bus_result_board;
        logic [6:0] own_address;
        logic [7:0] last_index;
        logic [3:0] phase;
        logic [7:0] pointer;
        logic       pointer_pending;
        logic       stop_seen;
        logic [7:0] byte_store [256];
        rsp_word_t  due_results [$];
        int         fault_count;

        function new();
            own_address     = 7'd0;
            last_index      = 8'hff;
            phase           = PH_IDLE;
            pointer         = 8'h00;
            pointer_pending = 1'b0;
            stop_seen       = 1'b1;
            fault_count     = 0;
            foreach (byte_store[i])
                byte_store[i] = 8'h00;
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] index, logic [7:0] data);
            if (index == CFG_OWN_ADDRESS)
                own_address = data[6:0];
            else if (index == CFG_LAST_INDEX)
                last_index = data;
        endfunction

        // advance the slave state by one accepted event word and queue its result
        function void take_event(evt_word_t w);
            rsp_word_t  r;
            logic [3:0] ph;
            logic       accept;
            r.action  = ACT_NONE;
            r.tx_byte = 8'h00;
            ph        = phase;
            case (w.kind)
                KIND_START:
                begin
                    ph        = stop_seen ? PH_START : PH_RSTART;
                    stop_seen = 1'b0;
                    r.action  = ACT_RECV;
                end
                KIND_STOP:
                    stop_seen = 1'b1;
                KIND_SHIFT:
                begin
                    case (ph)
                        PH_START, PH_RSTART:
                        begin
                            // only a fresh start rewinds the pointer
                            if (ph == PH_START)
                                pointer = 8'h00;
                            if (w.line_byte[7:1] == own_address)
                            begin
                                ph = ((w.line_byte & RW_READ_MASK) != 8'h00) ?
                                     PH_R_ADDR : PH_W_ADDR;
                                r.action = ACT_ACK;
                            end
                            else
                            begin
                                ph        = PH_IDLE;
                                stop_seen = 1'b0;
                                r.action  = ACT_IDLE;
                            end
                        end
                        PH_W_ADDR, PH_W_ACKED:
                        begin
                            if (ph == PH_W_ADDR)
                                pointer_pending = 1'b1;
                            ph       = PH_W_TOACK;
                            r.action = ACT_RECV;
                        end
                        PH_W_TOACK:
                        begin
                            if (pointer_pending)
                            begin
                                pointer         = w.line_byte;
                                pointer_pending = 1'b0;
                                ph              = PH_W_ACKED;
                                r.action        = ACT_ACK;
                            end
                            else
                            begin
                                accept              = pointer < last_index;
                                byte_store[pointer] = w.line_byte;
                                pointer             = pointer + 8'd1;
                                ph                  = accept ? PH_W_ACKED : PH_W_NACKED;
                                r.action            = accept ? ACT_ACK : ACT_NACK;
                            end
                        end
                        PH_W_NACKED:
                        begin
                            ph        = PH_IDLE;
                            stop_seen = 1'b0;
                            r.action  = ACT_IDLE;
                        end
                        PH_R_CHECK, PH_R_ADDR:
                        begin
                            if (ph == PH_R_CHECK &&
                                (w.line_byte != 8'h00 || pointer > last_index))
                            begin
                                ph        = PH_IDLE;
                                stop_seen = 1'b0;
                                r.action  = ACT_IDLE;
                            end
                            else
                            begin
                                r.tx_byte = byte_store[pointer];
                                pointer   = pointer + 8'd1;
                                ph        = PH_R_SENT;
                                r.action  = ACT_SEND;
                            end
                        end
                        PH_R_SENT:
                        begin
                            ph       = PH_R_CHECK;
                            r.action = ACT_RDACK;
                        end
                        default:
                            ph = PH_IDLE;
                    endcase
                end
                default:
                    ;
            endcase
            phase   = ph;
            r.phase = ph;
            due_results.push_back(r);
        endfunction

        function void check_result(rsp_word_t got);
            rsp_word_t want;
            if (due_results.size() == 0)
            begin
                $display("%0t: unexpected result word: action %0d tx_byte %02h phase %0d",
                         $time, got.action, got.tx_byte, got.phase);
                fault_count++;
                return;
            end
            want = due_results.pop_front();
            if (got.action !== want.action)
            begin
                $display("%0t: action mismatch: expected %0d, actual %0d",
                         $time, want.action, got.action);
                fault_count++;
            end
            if (got.tx_byte !== want.tx_byte)
            begin
                $display("%0t: tx_byte mismatch: expected %02h, actual %02h",
                         $time, want.tx_byte, got.tx_byte);
                fault_count++;
            end
            if (got.phase !== want.phase)
            begin
                $display("%0t: phase mismatch: expected %0d, actual %0d",
                         $time, want.phase, got.phase);
                fault_count++;
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // clock, reset and block signals, all known from time zero
    // ------------------------------------------------------------------------
    logic                 clk        = 1'b0;
    logic                 rst_n      = 1'b0;
    logic                 evt_valid  = 1'b0;
    logic                 evt_ready;
    evt_word_t            evt_word   = '0;
    logic                 rsp_valid;
    logic                 rsp_ready  = 1'b0;
    rsp_word_t            rsp_word;
    logic                 cfg_we     = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index  = CFG_OWN_ADDRESS;
    logic [7:0]           cfg_data   = 8'h00;

    bus_result_board board;
    int              send_idle_pct  = 0;   // chance in a hundred of a sender gap cycle
    int              recv_stall_pct = 0;   // chance in a hundred of holding ready low
    int              words_sent     = 0;
    int              cycle_count    = 0;

    initial
    begin
        forever #10 clk = ~clk;
    end

    i2c_slave_register_port_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .evt_valid (evt_valid),
        .evt_ready (evt_ready),
        .evt_word  (evt_word),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp_word  (rsp_word),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // receiver side: ready changes on the falling edge, one decision per cycle
    always @(negedge clk)
        rsp_ready <= ($urandom_range(99) >= recv_stall_pct);

    // results are taken at the rising edge, before the block updates
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && rsp_ready)
            board.check_result(rsp_word);
    end

    // watchdog against a hung handshake
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // sender tasks, always entered and left on a falling edge
    // ------------------------------------------------------------------------

    // present one event word; valid is only lowered when a gap is taken, so it
    // never gets two updates in one step
    task automatic send_event(input logic [1:0] kind, input logic [7:0] line_byte);
        evt_word_t w;
        int        gap;
        w.kind      = kind;
        w.line_byte = line_byte;
        gap         = 0;
        while ($urandom_range(99) < send_idle_pct)
            gap++;
        if (gap > 0)
        begin
            evt_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        evt_valid <= 1'b1;
        evt_word  <= w;
        do
            @(posedge clk);
        while (!evt_ready);
        board.take_event(w);
        words_sent++;
        @(negedge clk);
    endtask

    // drop valid, let every due result arrive, then keep the block idle for the extra cycles requested
    task automatic wait_drained(input int extra);
        evt_valid <= 1'b0;
        do
            @(negedge clk);
        while (board.due_results.size() != 0);
        repeat (extra) @(negedge clk);
    endtask

    // both registers are written back to back, only while the block is idle
    task automatic write_registers(input logic [6:0] own, input logic [7:0] last);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_OWN_ADDRESS;
        cfg_data  <= {1'b0, own};
        @(negedge clk);
        cfg_index <= CFG_LAST_INDEX;
        cfg_data  <= last;
        @(negedge clk);
        cfg_we    <= 1'b0;
        board.set_register(CFG_OWN_ADDRESS, {1'b0, own});
        board.set_register(CFG_LAST_INDEX, last);
    endtask

    // read body after the address byte: bytes out, master ack bits in
    task automatic read_bytes();
        int         n;
        logic [7:0] ack;
        if (board.phase != PH_R_ADDR)
            return;
        n = $urandom_range(1, 10);
        send_event(KIND_SHIFT, 8'($urandom));
        while (n > 0 && board.phase == PH_R_SENT)
        begin
            send_event(KIND_SHIFT, 8'($urandom));
            // mostly acks, the odd nack, and often a nack on the last byte
            ack = ($urandom_range(99) < 85) ? 8'h00 : 8'($urandom_range(1, 255));
            if (n == 1 && $urandom_range(1) == 1)
                ack = 8'($urandom_range(1, 255));
            send_event(KIND_SHIFT, ack);
            n--;
        end
    endtask

    // one bus transaction: well-formed write or read with random content, or noise
    task automatic run_transaction();
        int         pick;
        int         n;
        logic [7:0] addr_byte;
        logic [7:0] ptr;
        pick = $urandom_range(99);
        if (pick < 10)
        begin
            // stray events of any kind, the unused one too
            n = $urandom_range(1, 4);
            repeat (n) send_event(2'($urandom_range(3)), 8'($urandom));
            return;
        end
        send_event(KIND_START, 8'($urandom));
        addr_byte = {board.own_address, 1'b0};
        if ($urandom_range(9) == 0)
            addr_byte[7:1] = 7'($urandom);
        if (pick < 55)
        begin
            send_event(KIND_SHIFT, addr_byte);
            if (board.phase == PH_W_ADDR)
            begin
                send_event(KIND_SHIFT, 8'($urandom));
                ptr = ($urandom_range(1) == 1) ? 8'($urandom_range(board.last_index)) :
                                                 8'($urandom);
                send_event(KIND_SHIFT, ptr);
                n = $urandom_range(0, 8);
                while (n > 0 && board.phase == PH_W_ACKED)
                begin
                    send_event(KIND_SHIFT, 8'($urandom));
                    send_event(KIND_SHIFT, 8'($urandom));
                    n--;
                end
                if (board.phase == PH_W_NACKED && $urandom_range(1) == 1)
                    send_event(KIND_SHIFT, 8'($urandom));
            end
            // pointer set by the write, then a repeated start into a read
            if ($urandom_range(99) < 25)
            begin
                send_event(KIND_START, 8'($urandom));
                addr_byte[0] = 1'b1;
                send_event(KIND_SHIFT, addr_byte);
                read_bytes();
            end
        end
        else
        begin
            addr_byte[0] = 1'b1;
            send_event(KIND_SHIFT, addr_byte);
            read_bytes();
        end
        // usually a stop; otherwise the next start is a repeated one
        if ($urandom_range(99) < 85)
            send_event(KIND_STOP, 8'($urandom));
    endtask

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        int         p;
        int         phase_end;
        logic       paused;
        logic [6:0] own;
        logic [7:0] last;

        board = new();
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed part at reset settings: address 0, last index 255
        send_event(KIND_SHIFT, 8'hff);      // shift while idle is ignored
        send_event(2'd3, 8'haa);            // unused event kind
        send_event(KIND_STOP, 8'h00);       // stop while idle
        send_event(KIND_START, 8'h00);      // fresh start
        send_event(KIND_SHIFT, 8'h00);      // write to address 0
        send_event(KIND_SHIFT, 8'h00);
        send_event(KIND_SHIFT, 8'hfe);      // pointer near the top
        send_event(KIND_SHIFT, 8'h00);
        send_event(KIND_SHIFT, 8'h5a);      // below last index: ack
        send_event(KIND_SHIFT, 8'h00);
        send_event(KIND_SHIFT, 8'ha5);      // at last index: nack, pointer wraps
        send_event(KIND_SHIFT, 8'h00);      // refused write goes idle
        send_event(KIND_START, 8'hff);      // repeated start keeps the pointer
        send_event(KIND_SHIFT, 8'h01);      // read from address 0
        send_event(KIND_SHIFT, 8'h00);
        send_event(KIND_SHIFT, 8'h00);
        send_event(KIND_SHIFT, 8'h00);      // master ack: next byte
        send_event(KIND_SHIFT, 8'h00);
        send_event(KIND_SHIFT, 8'h01);      // master nack ends the read
        send_event(KIND_STOP, 8'hff);
        send_event(KIND_START, 8'h00);
        send_event(KIND_SHIFT, 8'h02);      // address mismatch goes idle

        // random part: one register setting and one idling mode per phase
        for (p = 0; p < PHASE_COUNT; p++)
        begin
            wait_drained(3);
            case (p)
                0:       begin own = 7'd127;          last = 8'd0;                    end
                1:       begin own = 7'd0;            last = 8'd255;                  end
                2:       begin own = 7'($urandom);    last = 8'($urandom_range(1, 8));  end
                3:       begin own = 7'($urandom);    last = 8'($urandom);            end
                4:       begin own = 7'd127;          last = 8'($urandom_range(0, 3));  end
                5:       begin own = 7'($urandom);    last = 8'd255;                  end
                6:       begin own = 7'd0;            last = 8'($urandom_range(4, 16)); end
                default: begin own = 7'($urandom);    last = 8'($urandom);            end
            endcase
            write_registers(own, last);
            case (p % 4)
                0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1:       begin send_idle_pct = 57; recv_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  recv_stall_pct = 57; end
                default: begin send_idle_pct = 21; recv_stall_pct = 21; end
            endcase
            phase_end = words_sent + WORDS_PER_PHASE;
            paused    = 1'b0;
            while (words_sent < phase_end)
            begin
                run_transaction();
                // halfway through, hold off until the block has caught up
                if (!paused && words_sent >= phase_end - WORDS_PER_PHASE / 2)
                begin
                    wait_drained(0);
                    paused = 1'b1;
                end
            end
        end

        wait_drained(8);
        if (board.fault_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
`default_nettype wire
